// ----- sv/nttw_pkg.sv -----
// shared constants and types for the ntt twiddle factor generator
// modulus, montgomery constants, power table geometry, build sequencer states
// no dependencies
`default_nettype none

package nttw_pkg;

  localparam int unsigned FieldW = 23;

  // q = 2^23 - 2^13 + 1
  localparam logic [FieldW-1:0] Q = 23'((64'd1 << 23) - (64'd1 << 13) + 64'd1);
  // -q^-1 mod 2^32
  localparam logic [31:0] QinvNeg = 32'd4236238847;
  localparam logic [31:0] Low32Mask = 32'd4294967295;

  localparam int unsigned PrimitiveRoot = 1753;
  localparam int unsigned MaxLevel = 8;

  localparam int unsigned TableDepth = 512;
  localparam int unsigned TableAddrW = $clog2(TableDepth);
  localparam logic [TableAddrW-1:0] TableLast = TableAddrW'(TableDepth - 1);

  // montgomery form constants, R = 2^32
  localparam logic [FieldW-1:0] MontOne = 23'((64'd1 << 32) % 64'(Q));
  localparam logic [FieldW-1:0] MontRoot = 23'((64'(PrimitiveRoot) << 32) % 64'(Q));
  localparam logic [FieldW-1:0] HalfMont =
    23'((((64'(Q) + 64'd1) / 64'd2) << 32) % 64'(Q));

  // register stages inside the montgomery multiplier
  localparam int unsigned MulLatency = 4;

  typedef enum logic [1:0] {
    BldIssue,
    BldWait,
    BldDone
  } bld_state_t;

  // item data carried next to the multiplier
  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic              in_range;
    logic [FieldW-1:0] fwd;
  } side_t;

endpackage

`default_nettype wire

// ----- sv/nttw_ram.sv -----
// generic single write port ram with registered read port
// no dependencies
`default_nettype none

module nttw_ram #(
  parameter int unsigned Width = 23,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/nttw_mont_mul.sv -----
// pipelined montgomery multiplier mod q with R = 2^32, four register stages
// product, redc quotient, redc sum, final conditional subtract
// depends on nttw_pkg
`default_nettype none

module nttw_mont_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire logic [nttw_pkg::FieldW-1:0] a,
  input  wire logic [nttw_pkg::FieldW-1:0] b,
  output logic                            valid_out,
  output logic      [nttw_pkg::FieldW-1:0] result
);

  logic        v1, v2, v3;
  logic [45:0] p1, p2;
  logic [31:0] m2;
  logic [23:0] t3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1        <= valid_in;
      v2        <= v1;
      v3        <= v2;
      valid_out <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= 46'(a) * 46'(b);
      p2 <= p1;
      // low 32 bits only
      m2 <= 32'(p1[31:0] * nttw_pkg::QinvNeg) & nttw_pkg::Low32Mask;
      t3 <= 24'((56'(p2) + 56'(m2) * 56'(nttw_pkg::Q)) >> 32);
      result <= (t3 >= 24'(nttw_pkg::Q)) ? 23'(t3 - 24'(nttw_pkg::Q)) : t3[22:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/ntt_twiddle_factor_generator.sv -----
// top level of the ntt twiddle factor generator for q = 8380417, montgomery form
// holds the power table build sequencer and the lookup pipeline
// depends on nttw_pkg, nttw_ram, nttw_mont_mul
//
// usage:
//   request channel (req_valid/req_stall) carries command, level and group;
//   response channel (rsp_valid/rsp_stall) carries twiddle and negated_twiddle,
//   one response transaction per request transaction, in order.
//   after reset the block fills its 512-entry power table of 1753^i, one entry
//   at a time through the montgomery multiplier; req_stall stays high until
//   the table is complete.
//   a request passes the table read register, the montgomery multiplier and
//   the output register, in that order, on its way to the response.
//   throughput is one transaction per cycle; the whole lookup pipeline moves
//   as one, so when the receiver stalls a full output register, the pipeline
//   freezes and req_stall rises in the same cycle. nothing is dropped or
//   repeated.
//   groups at or above 2^level, and levels above eight, give zero results.
`default_nettype none

module ntt_twiddle_factor_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        command,
  input  wire logic [3:0]  level,
  input  wire logic [7:0]  group,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic      [22:0] twiddle,
  output logic      [22:0] negated_twiddle
);

  // table build sequencer
  nttw_pkg::bld_state_t                  state, state_next;
  logic [nttw_pkg::TableAddrW-1:0]       idx, idx_next;
  logic [nttw_pkg::FieldW-1:0]           acc, acc_next;
  logic                                  bld_we;
  logic                                  bld_mul_valid;
  logic                                  bld_res_valid;
  logic [nttw_pkg::FieldW-1:0]           bld_res;
  logic                                  built;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nttw_pkg::BldIssue;
      idx   <= '0;
      acc   <= nttw_pkg::MontOne;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      acc   <= acc_next;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    acc_next      = acc;
    bld_we        = 1'b0;
    bld_mul_valid = 1'b0;
    case (state)
      nttw_pkg::BldIssue: begin
        bld_we = 1'b1;
        if (idx == nttw_pkg::TableLast) begin
          state_next = nttw_pkg::BldDone;
        end else begin
          bld_mul_valid = 1'b1;
          state_next    = nttw_pkg::BldWait;
        end
      end
      nttw_pkg::BldWait: begin
        if (bld_res_valid) begin
          acc_next   = bld_res;
          idx_next   = idx + 1'b1;
          state_next = nttw_pkg::BldIssue;
        end
      end
      nttw_pkg::BldDone: begin
        state_next = nttw_pkg::BldDone;
      end
      default: begin
        state_next = nttw_pkg::BldIssue;
      end
    endcase
  end

  assign built = (state == nttw_pkg::BldDone);

  nttw_mont_mul u_bld_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (1'b1),
    .valid_in  (bld_mul_valid),
    .a         (acc),
    .b         (nttw_pkg::MontRoot),
    .valid_out (bld_res_valid),
    .result    (bld_res)
  );

  // lookup pipeline, one enable for every stage
  logic                            adv;
  logic                            req_accept;
  logic [7:0]                      e;
  logic [nttw_pkg::TableAddrW-1:0] e_addr;
  logic [nttw_pkg::TableAddrW-1:0] rd_addr;
  logic                            in_range;
  logic [nttw_pkg::FieldW-1:0]     ram_rdata;

  assign adv        = !rsp_valid || !rsp_stall;
  assign req_stall  = !adv || !built;
  assign req_accept = req_valid && !req_stall;

  // with group below 2^level the root index is just group bit-reversed over 8 bits
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      e[7-j] = group[j];
    end
  end

  assign e_addr   = {{(nttw_pkg::TableAddrW-8){1'b0}}, e};
  // inverse exponent is -e mod table depth
  assign rd_addr  = command ? (~e_addr + 1'b1) : e_addr;
  assign in_range = (level <= 4'(nttw_pkg::MaxLevel)) && ((group >> level) == 8'd0);

  nttw_ram #(
    .Width (nttw_pkg::FieldW),
    .Depth (nttw_pkg::TableDepth)
  ) u_table (
    .clk   (clk),
    .we    (bld_we),
    .waddr (idx),
    .wdata (acc),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  logic a_valid;
  logic a_cmd;
  logic a_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= req_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd   <= command;
      a_range <= in_range;
    end
  end

  logic                        mul_valid;
  logic [nttw_pkg::FieldW-1:0] mul_res;

  nttw_mont_mul u_item_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (a_valid),
    .a         (ram_rdata),
    .b         (nttw_pkg::HalfMont),
    .valid_out (mul_valid),
    .result    (mul_res)
  );

  nttw_pkg::side_t side [nttw_pkg::MulLatency];
  nttw_pkg::side_t side_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < nttw_pkg::MulLatency; k++) begin
        side[k].valid <= 1'b0;
      end
    end else if (adv) begin
      side[0].valid <= a_valid;
      for (int k = 1; k < nttw_pkg::MulLatency; k++) begin
        side[k].valid <= side[k-1].valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].cmd      <= a_cmd;
      side[0].in_range <= a_range;
      side[0].fwd      <= ram_rdata;
      for (int k = 1; k < nttw_pkg::MulLatency; k++) begin
        side[k].cmd      <= side[k-1].cmd;
        side[k].in_range <= side[k-1].in_range;
        side[k].fwd      <= side[k-1].fwd;
      end
    end
  end

  assign side_last = side[nttw_pkg::MulLatency-1];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= side_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!side_last.in_range) begin
        twiddle         <= '0;
        negated_twiddle <= '0;
      end else if (side_last.cmd) begin
        twiddle         <= mul_res;
        negated_twiddle <= '0;
      end else begin
        twiddle         <= side_last.fwd;
        negated_twiddle <= nttw_pkg::Q - side_last.fwd;
      end
    end
  end

  // no item reaches the pipeline before the table is complete
  assert property (@(posedge clk) disable iff (rst) a_valid |-> built)
    else $error("item entered pipeline before table build finished");

  // sideband stays aligned with the multiplier output
  assert property (@(posedge clk) disable iff (rst) mul_valid == side_last.valid)
    else $error("multiplier valid and sideband valid out of step");

  // inverse results never carry a negated twiddle
  assert property (@(posedge clk) disable iff (rst)
    (adv && side_last.valid && side_last.cmd) |=> (negated_twiddle == '0))
    else $error("inverse transaction with nonzero negated twiddle");

  // build finishes only after the last table entry
  assert property (@(posedge clk) disable iff (rst)
    $rose(built) |-> ($past(idx) == nttw_pkg::TableLast))
    else $error("table build ended early");

endmodule

`default_nettype wire
